FILE: hw/rtl/xmte_pkg.sv
// xmte_pkg: shared types, constants and the xorshift pattern function for the
// xorshift memory test engine; no dependencies, imported by every rtl module

package xmte_pkg;

  // index range of the tested region, 2^INDEX_BITS words at most
  localparam int INDEX_BITS = 29;
  localparam int CNT_W      = INDEX_BITS + 1;

  localparam int SEED_W     = 64;
  localparam int BASE_W     = 32;
  localparam int WCOUNT_W   = 30;
  localparam int LOOP_W     = 16;
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 33;
  localparam int ERR_W      = 32;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;

  // compare width for the last-word test
  localparam int CMP_W = (WCOUNT_W > CNT_W) ? WCOUNT_W : CNT_W;

  localparam logic [SEED_W-1:0]   SEED_RESET   = 64'hAF5469CD67582A93;
  localparam logic [BASE_W-1:0]   BASE_RESET   = '0;
  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = WCOUNT_W'(131072);
  localparam logic [LOOP_W-1:0]   LOOP_RESET   = LOOP_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT   = 2'd3;

  // opcodes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // phase codes, also the state encoding of the test sequencer
  localparam logic [PHASE_W-1:0] PH_FILL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CHECK = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE  = 2'd2;

  // xorshift shift amounts
  localparam int SH_A = 13;
  localparam int SH_B = 7;
  localparam int SH_C = 17;

  typedef struct packed {
    logic [SEED_W-1:0]   seed_base;
    logic [BASE_W-1:0]   base_address;
    logic [WCOUNT_W-1:0] word_count;
    logic [LOOP_W-1:0]   loop_count;
  } cfg_t;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] read_data;
  } step_req_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ADDR_W-1:0]  word_address;
    logic [DATA_W-1:0]  pattern_word;
    logic               mismatch;
    logic [DATA_W-1:0]  error_mask;
    logic [ERR_W-1:0]   error_total;
    logic [LOOP_W-1:0]  pass_number;
    logic               pass_end;
  } result_t;

  function automatic logic [SEED_W-1:0] xorshift64(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    a = x ^ (x << SH_A);
    b = a ^ (a >> SH_B);
    return b ^ (b << SH_C);
  endfunction

endpackage

FILE: hw/rtl/xorshift_memory_test_engine_unit.sv
// xorshift_memory_test_engine_unit: top level of the xorshift memory test engine
// depends on xmte_pkg, xmte_cfg_regs and xmte_step
//
// usage
//   input channel (in_valid_i / in_ready_o): one beat is one step request;
//   opcode_i restarts the whole test or advances one word, read_data_i
//   carries the word read back from memory during the check phase
//   output channel (out_valid_o / out_ready_i): one result beat per request,
//   giving the write to issue (fill phase), the compare outcome (check
//   phase) or the done status
//   config channel (cfg_valid_i / cfg_ready_o): cfg_index_i selects seed
//   base, base address, word count or loop count; always ready, write only
//   while the engine is idle
// timing
//   a beat lands in the request register and is then stepped into the output
//   register once the result side can load; one beat per cycle sustained while
//   the receiver keeps out_ready_i high, set by the generator and index feedback
// reset
//   configuration returns to its defaults, generator holds the default seed,
//   index, pass and error count clear, the test begins in the fill phase
// stall
//   if the receiver holds off, the result register and the request register
//   both fill and in_ready_o drops; nothing is lost or repeated

module xorshift_memory_test_engine_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [xmte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [xmte_pkg::SEED_W-1:0]     cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [xmte_pkg::DATA_W-1:0]     read_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [xmte_pkg::PHASE_W-1:0]    phase_o,
  output logic [xmte_pkg::ADDR_W-1:0]     word_address_o,
  output logic [xmte_pkg::DATA_W-1:0]     pattern_word_o,
  output logic                            mismatch_o,
  output logic [xmte_pkg::DATA_W-1:0]     error_mask_o,
  output logic [xmte_pkg::ERR_W-1:0]      error_total_o,
  output logic [xmte_pkg::LOOP_W-1:0]     pass_number_o,
  output logic                            pass_end_o
);
  import xmte_pkg::*;

  cfg_t      cfg;
  step_req_t req_q;
  result_t   step_res;
  result_t   res_q;
  logic      req_valid_q;
  logic      out_valid_q;
  logic      out_load;
  logic      step_en;
  logic      in_fire;

  // config registers take a beat every cycle
  assign cfg_ready_o = 1'b1;

  xmte_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // result register can load when empty or being drained this cycle
  assign out_load   = !out_valid_q || out_ready_i;
  // request register steps when it holds a beat and the result side can load
  assign step_en    = req_valid_q && out_load;
  assign in_ready_o = !req_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_fire) begin
      req_valid_q <= 1'b1;
    end else if (step_en) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.opcode    <= opcode_i;
      req_q.read_data <= read_data_i;
    end
  end

  xmte_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .req_i     (req_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign phase_o        = res_q.phase;
  assign word_address_o = res_q.word_address;
  assign pattern_word_o = res_q.pattern_word;
  assign mismatch_o     = res_q.mismatch;
  assign error_mask_o   = res_q.error_mask;
  assign error_total_o  = res_q.error_total;
  assign pass_number_o  = res_q.pass_number;
  assign pass_end_o     = res_q.pass_end;

`ifndef ASSERT_OFF
  // mismatch flag agrees with the error mask
  a_mask_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mismatch_o == (error_mask_o != '0)))
    else $error("mismatch flag disagrees with error mask");

  // only check beats carry a mismatch or a pass end
  a_check_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mismatch_o || pass_end_o)) |-> (phase_o == PH_CHECK))
    else $error("mismatch or pass end outside check phase");

  // backpressure only when both registers hold a beat
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result side can take a beat");

  // a stepped request always shows up as a result next cycle
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_valid_o)
    else $error("step result lost");
`endif

endmodule

FILE: hw/rtl/xmte_cfg_regs.sv
// xmte_cfg_regs: configuration register file of the memory test engine
// depends on xmte_pkg

module xmte_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [xmte_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [xmte_pkg::SEED_W-1:0]    wr_data_i,
  output xmte_pkg::cfg_t                 cfg_o
);
  import xmte_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_SEED_BASE:    cfg_d.seed_base    = wr_data_i;
        REG_BASE_ADDRESS: cfg_d.base_address = wr_data_i[BASE_W-1:0];
        REG_WORD_COUNT:   cfg_d.word_count   = wr_data_i[WCOUNT_W-1:0];
        REG_LOOP_COUNT:   cfg_d.loop_count   = wr_data_i[LOOP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed_base    <= SEED_RESET;
      cfg_q.base_address <= BASE_RESET;
      cfg_q.word_count   <= WCOUNT_RESET;
      cfg_q.loop_count   <= LOOP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/xmte_step.sv
// xmte_step: test sequencer state and the combinational step logic
// depends on xmte_pkg (types, phase codes, xorshift64)

module xmte_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  xmte_pkg::step_req_t req_i,
  input  xmte_pkg::cfg_t      cfg_i,
  output xmte_pkg::result_t   res_o
);
  import xmte_pkg::*;

  logic [SEED_W-1:0]     gen_q, gen_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [LOOP_W-1:0]     pass_q, pass_d;
  logic [ERR_W-1:0]      err_q, err_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;

  logic [CMP_W-1:0]  wc_ext;
  logic [CMP_W-1:0]  eff_words;
  logic              last;
  logic [SEED_W-1:0] pat;
  logic [DATA_W-1:0] mask;
  logic [LOOP_W-1:0] pass_inc;
  logic [LOOP_W-1:0] loops;
  logic              final_pass;
  logic [LOOP_W-1:0] reload_pass;
  logic [SEED_W-1:0] reload_seed;

  // effective word count: clamp to 2^INDEX_BITS, zero acts as one
  always_comb begin
    wc_ext = CMP_W'(cfg_i.word_count);
    if (wc_ext > (CMP_W'(1) << INDEX_BITS)) begin
      eff_words = CMP_W'(1) << INDEX_BITS;
    end else if (wc_ext == '0) begin
      eff_words = CMP_W'(1);
    end else begin
      eff_words = wc_ext;
    end
  end

  assign last        = (CMP_W'(idx_q) + CMP_W'(1)) >= eff_words;
  assign pat         = xorshift64(gen_q);
  assign mask        = req_i.read_data ^ pat;
  assign pass_inc    = pass_q + LOOP_W'(1);
  assign loops       = (cfg_i.loop_count == '0) ? LOOP_W'(1) : cfg_i.loop_count;
  assign final_pass  = ({1'b0, pass_q} + (LOOP_W+1)'(1)) >= {1'b0, loops};
  // fill reseeds with the current pass, check with the next one
  assign reload_pass = (phase_q == PH_CHECK) ? pass_inc : pass_q;
  assign reload_seed = cfg_i.seed_base + SEED_W'(reload_pass);

  always_comb begin
    gen_d   = gen_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    err_d   = err_q;
    phase_d = phase_q;
    res_o   = '0;

    if (req_i.opcode == OP_RESTART) begin
      gen_d       = cfg_i.seed_base;
      idx_d       = '0;
      pass_d      = '0;
      err_d       = '0;
      phase_d     = PH_FILL;
      res_o.phase = PH_DONE;
    end else begin
      case (phase_q)
        PH_FILL, PH_CHECK: begin
          gen_d              = pat;
          res_o.word_address = {1'b0, cfg_i.base_address} + ADDR_W'(idx_q);
          res_o.pattern_word = pat;
          res_o.pass_number  = pass_q;
          idx_d              = last ? '0 : idx_q + INDEX_BITS'(1);
          if (phase_q == PH_FILL) begin
            res_o.phase = PH_FILL;
            if (last) begin
              gen_d   = reload_seed;
              phase_d = PH_CHECK;
            end
          end else begin
            res_o.phase      = PH_CHECK;
            res_o.mismatch   = (mask != '0);
            res_o.error_mask = mask;
            res_o.pass_end   = last;
            if ((mask != '0) && (err_q != '1)) begin
              err_d = err_q + ERR_W'(1);
            end
            if (last) begin
              pass_d = pass_inc;
              if (final_pass) begin
                phase_d = PH_DONE;
              end else begin
                gen_d   = reload_seed;
                phase_d = PH_FILL;
              end
            end
          end
          res_o.error_total = err_d;
        end
        default: begin
          res_o.phase       = PH_DONE;
          res_o.error_total = err_q;
          res_o.pass_number = pass_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= SEED_RESET;
      idx_q   <= '0;
      pass_q  <= '0;
      err_q   <= '0;
      phase_q <= PH_FILL;
    end else if (step_en_i) begin
      gen_q   <= gen_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      err_q   <= err_d;
      phase_q <= phase_d;
    end
  end

endmodule
